[hw/rtl/zero_order_phase_correct_assert.svh]
// assertion macros shared by the checker
`ifndef ZERO_ORDER_PHASE_CORRECT_ASSERT_SVH
`define ZERO_ORDER_PHASE_CORRECT_ASSERT_SVH

// property under reset guard
`define ZOPC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("zopc assertion failed");

// implication whose consequent is checked in the following cycle
`define ZOPC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("zopc assertion failed");

`endif

[hw/rtl/zopc_pkg.sv]
`default_nettype none
package zopc_pkg;
	localparam int PHASE_POINTS_DEF = 30;
	localparam int SMP_W = 18;
	localparam int SUM_W = 24;
	localparam int ANG_W = 16;
	localparam int XY_W = 27;
	localparam int Z_W = 18;
	localparam int ITERS = 15;
	localparam int IT_W = 4;
	localparam int PROD_W = XY_W + 17;
	localparam logic [15:0] INV_GAIN = 16'd39797;

	typedef struct packed {
		logic take;
		logic vec_load;
		logic step;
		logic rd;
		logic rot_load;
		logic mul;
		logic emit;
	} zopc_cmd_t;

	typedef struct packed {
		logic phase_ready;
		logic go_vec;
		logic sum_zero;
		logic iter_last;
		logic out_free;
		logic more;
	} zopc_stat_t;

	function automatic logic [Z_W-1:0] atan_lut(input logic [IT_W-1:0] i);
		logic [Z_W-1:0] r;
		case (i)
			4'd0: r = 18'd8192;
			4'd1: r = 18'd4836;
			4'd2: r = 18'd2555;
			4'd3: r = 18'd1297;
			4'd4: r = 18'd651;
			4'd5: r = 18'd326;
			4'd6: r = 18'd163;
			4'd7: r = 18'd81;
			4'd8: r = 18'd41;
			4'd9: r = 18'd20;
			4'd10: r = 18'd10;
			4'd11: r = 18'd5;
			4'd12: r = 18'd3;
			4'd13: r = 18'd1;
			4'd14: r = 18'd1;
			default: r = '0;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

[hw/rtl/zopc_ctrl.sv]
`default_nettype none
module zopc_ctrl import zopc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic sample_valid,
	output logic sample_ready,
	input wire zopc_stat_t stat,
	output zopc_cmd_t cmd
);
	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_VEC_LOAD = 8'b0000_0010,
		ST_VEC_RUN = 8'b0000_0100,
		ST_RD = 8'b0000_1000,
		ST_ROT_LOAD = 8'b0001_0000,
		ST_ROT_RUN = 8'b0010_0000,
		ST_MUL = 8'b0100_0000,
		ST_EMIT = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		cmd = '0;
		state_d = state_q;
		sample_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				sample_ready = 1'b1;
				if (sample_valid) begin
					cmd.take = 1'b1;
					if (stat.phase_ready) state_d = ST_ROT_LOAD;
					else if (stat.go_vec) state_d = ST_VEC_LOAD;
				end
			end
			ST_VEC_LOAD: begin
				cmd.vec_load = 1'b1;
				state_d = stat.sum_zero ? ST_RD : ST_VEC_RUN;
			end
			ST_VEC_RUN: begin
				cmd.step = 1'b1;
				if (stat.iter_last) state_d = ST_RD;
			end
			ST_RD: begin
				cmd.rd = 1'b1;
				state_d = ST_ROT_LOAD;
			end
			ST_ROT_LOAD: begin
				cmd.rot_load = 1'b1;
				state_d = ST_ROT_RUN;
			end
			ST_ROT_RUN: begin
				cmd.step = 1'b1;
				if (stat.iter_last) state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d = stat.more ? ST_RD : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

[hw/rtl/zopc_dp.sv]
`default_nettype none
module zopc_dp import zopc_pkg::*; #(
	parameter int PHASE_POINTS = PHASE_POINTS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic signed [SMP_W-1:0] sample_real,
	input wire logic signed [SMP_W-1:0] sample_imag,
	input wire logic last_sample,
	output logic signed [SMP_W-1:0] rotated_real,
	output logic signed [SMP_W-1:0] rotated_imag,
	output logic last_out,
	output logic result_valid,
	input wire logic result_ready,
	input wire zopc_cmd_t cmd,
	output zopc_stat_t stat
);
	localparam int CNT_W = $clog2(PHASE_POINTS + 1);
	localparam int AW = (PHASE_POINTS > 1) ? $clog2(PHASE_POINTS) : 1;
	localparam logic [CNT_W:0] PP = (CNT_W + 1)'(PHASE_POINTS);
	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
	localparam logic signed [Z_W-1:0] QTR = 18'sd16384;
	localparam logic signed [Z_W-1:0] HALF = 18'sd32768;
	localparam logic signed [PROD_W-1:0] RND = PROD_W'(1) <<< 19;

	logic signed [SMP_W-1:0] mem_re [PHASE_POINTS];
	logic signed [SMP_W-1:0] mem_im [PHASE_POINTS];
	logic signed [SMP_W-1:0] rd_re_q, rd_im_q, smp_re_q, smp_im_q;
	logic signed [SUM_W-1:0] real_sum_q, imag_sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic [AW-1:0] rd_q;
	logic [ANG_W-1:0] phase_q;
	logic phase_ready_q, last_q, flush_q, vec_q;
	logic signed [XY_W-1:0] x_q, y_q;
	logic signed [Z_W-1:0] z_q;
	logic [IT_W-1:0] iter_q;
	logic signed [PROD_W-1:0] px_q, py_q;
	logic signed [SMP_W-1:0] out_re_q, out_im_q;
	logic out_last_q, out_valid_q;

	function automatic logic signed [SUM_W-1:0] sat_add(
		input logic signed [SUM_W-1:0] a, input logic signed [SMP_W-1:0] b);
		logic signed [SUM_W:0] s;
		s = (SUM_W+1)'(a) + (SUM_W+1)'(b);
		if (s > (SUM_W+1)'(SUM_MAX)) return SUM_MAX;
		if (s < (SUM_W+1)'(SUM_MIN)) return SUM_MIN;
		return s[SUM_W-1:0];
	endfunction

	function automatic logic signed [SMP_W-1:0] finish(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] r;
		r = (p + RND) >>> 20;
		if (r > PROD_W'(131071)) return 18'sh1FFFF;
		if (r < -PROD_W'(131072)) return 18'sh20000;
		return r[SMP_W-1:0];
	endfunction

	logic cw, more;
	logic signed [XY_W-1:0] xs, ys, vx0, vy0, rx0, ry0;
	logic signed [Z_W-1:0] at, rz0;
	logic signed [SMP_W-1:0] src_re, src_im;

	assign cw = vec_q ? (y_q > 0) : z_q[Z_W-1];
	assign xs = x_q >>> iter_q;
	assign ys = y_q >>> iter_q;
	assign at = atan_lut(iter_q);
	assign more = flush_q && ({1'b0, rd_q} + (AW+1)'(1) < (AW+1)'(cnt_q));

	always_comb begin
		vx0 = XY_W'(real_sum_q);
		vy0 = XY_W'(imag_sum_q);
		if (real_sum_q < 0) begin
			vx0 = -vx0;
			vy0 = -vy0;
		end
		src_re = flush_q ? rd_re_q : smp_re_q;
		src_im = flush_q ? rd_im_q : smp_im_q;
		rx0 = XY_W'(src_re) <<< 4;
		ry0 = XY_W'(src_im) <<< 4;
		rz0 = Z_W'($signed(-phase_q));
		if (rz0 > QTR) begin
			rx0 = -rx0;
			ry0 = -ry0;
			rz0 = rz0 - HALF;
		end else if (rz0 < -QTR) begin
			rx0 = -rx0;
			ry0 = -ry0;
			rz0 = rz0 + HALF;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && !phase_ready_q) begin
			mem_re[cnt_q[AW-1:0]] <= sample_real;
			mem_im[cnt_q[AW-1:0]] <= sample_imag;
		end
		if (cmd.rd) begin
			rd_re_q <= mem_re[rd_q];
			rd_im_q <= mem_im[rd_q];
		end
		if (cmd.take) begin
			smp_re_q <= sample_real;
			smp_im_q <= sample_imag;
		end
		if (cmd.vec_load) begin
			x_q <= vx0;
			y_q <= vy0;
			z_q <= (real_sum_q < 0) ? HALF : '0;
		end else if (cmd.rot_load) begin
			x_q <= rx0;
			y_q <= ry0;
			z_q <= rz0;
		end else if (cmd.step) begin
			if (cw) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end
		end
		if (cmd.mul) begin
			px_q <= PROD_W'(x_q) * $signed({1'b0, INV_GAIN});
			py_q <= PROD_W'(y_q) * $signed({1'b0, INV_GAIN});
		end
		if (cmd.emit) begin
			out_re_q <= finish(px_q);
			out_im_q <= finish(py_q);
			out_last_q <= last_q && !more;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			real_sum_q <= '0;
			imag_sum_q <= '0;
			cnt_q <= '0;
			rd_q <= '0;
			phase_q <= '0;
			phase_ready_q <= 1'b0;
			last_q <= 1'b0;
			flush_q <= 1'b0;
			vec_q <= 1'b0;
			iter_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.take) begin
				last_q <= last_sample;
				if (!phase_ready_q) begin
					cnt_q <= cnt_q + CNT_W'(1);
					real_sum_q <= sat_add(real_sum_q, sample_real);
					imag_sum_q <= sat_add(imag_sum_q, sample_imag);
				end
			end
			if (cmd.vec_load) begin
				vec_q <= 1'b1;
				flush_q <= 1'b1;
				rd_q <= '0;
				if (real_sum_q == 0 && imag_sum_q == 0) phase_q <= '0;
			end
			if (cmd.rot_load) vec_q <= 1'b0;
			if (cmd.vec_load || cmd.rot_load) iter_q <= '0;
			else if (cmd.step) begin
				iter_q <= iter_q + IT_W'(1);
				if (vec_q && iter_q == IT_W'(ITERS - 1))
					phase_q <= cw ? ANG_W'(z_q + at) : ANG_W'(z_q - at);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				if (more) rd_q <= rd_q + AW'(1);
				else begin
					flush_q <= 1'b0;
					if (flush_q) phase_ready_q <= 1'b1;
					if (last_q) begin
						real_sum_q <= '0;
						imag_sum_q <= '0;
						cnt_q <= '0;
						phase_ready_q <= 1'b0;
					end
				end
			end else if (result_ready) out_valid_q <= 1'b0;
		end
	end

	assign stat.phase_ready = phase_ready_q;
	assign stat.go_vec = ((CNT_W+1)'(cnt_q) + (CNT_W+1)'(1) >= PP) || last_sample;
	assign stat.sum_zero = (real_sum_q == 0) && (imag_sum_q == 0);
	assign stat.iter_last = (iter_q == IT_W'(ITERS - 1));
	assign stat.out_free = !out_valid_q || result_ready;
	assign stat.more = more;

	assign rotated_real = out_re_q;
	assign rotated_imag = out_im_q;
	assign last_out = out_last_q;
	assign result_valid = out_valid_q;
endmodule
`default_nettype wire

[hw/rtl/zero_order_phase_correct.sv]
// head samples: no result until the head completes, one transfer per cycle
// head flush: a load state plus 15 vectoring steps (the load alone when both sums are zero),
// then per held sample a read, a rotate load, 15 rotation steps, a multiply and an emit
// streaming: each sample after the head runs through the shared 15-step cordic unit
// an output register holds one result; the next sample is taken while it waits
// arst_n clears sums, head count, phase state and output valid; buffer needs no reset
`default_nettype none
module zero_order_phase_correct import zopc_pkg::*; #(
	parameter int PHASE_POINTS = PHASE_POINTS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic sample_valid,
	output logic sample_ready,
	input wire logic signed [SMP_W-1:0] sample_real,
	input wire logic signed [SMP_W-1:0] sample_imag,
	input wire logic last_sample,
	output logic result_valid,
	input wire logic result_ready,
	output logic signed [SMP_W-1:0] rotated_real,
	output logic signed [SMP_W-1:0] rotated_imag,
	output logic last_out
);
	zopc_cmd_t cmd;
	zopc_stat_t stat;

	zopc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.stat(stat),
		.cmd(cmd)
	);

	zopc_dp #(.PHASE_POINTS(PHASE_POINTS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.sample_real(sample_real),
		.sample_imag(sample_imag),
		.last_sample(last_sample),
		.rotated_real(rotated_real),
		.rotated_imag(rotated_imag),
		.last_out(last_out),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.cmd(cmd),
		.stat(stat)
	);
endmodule
`default_nettype wire

[hw/rtl/zopc_checker.sv]
`default_nettype none
`include "zero_order_phase_correct_assert.svh"
module zopc_checker import zopc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic sample_valid,
	input wire logic sample_ready,
	input wire logic result_valid,
	input wire logic result_ready,
	input wire logic signed [SMP_W-1:0] rotated_real,
	input wire logic signed [SMP_W-1:0] rotated_imag,
	input wire logic last_out
);
	`ZOPC_ASSERT_NEXT(a_out_hold, result_valid && !result_ready, result_valid)
	`ZOPC_ASSERT_NEXT(a_out_stable, result_valid && !result_ready,
		$stable(rotated_real) && $stable(rotated_imag) && $stable(last_out))
	`ZOPC_ASSERT_NEXT(a_no_fast_result, sample_valid && sample_ready, !$rose(result_valid))
	`ZOPC_ASSERT(a_ready_known, !$isunknown(sample_ready))
endmodule

bind zero_order_phase_correct zopc_checker u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.sample_valid(sample_valid),
	.sample_ready(sample_ready),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.rotated_real(rotated_real),
	.rotated_imag(rotated_imag),
	.last_out(last_out)
);
`default_nettype wire

[tb/zopc_phase_checker.sv]
`timescale 1ns / 1ps
module zopc_phase_checker import zopc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic sample_valid,
	input wire logic sample_ready,
	input wire logic signed [SMP_W-1:0] sample_real,
	input wire logic signed [SMP_W-1:0] sample_imag,
	input wire logic last_sample,
	input wire logic result_valid,
	input wire logic result_ready,
	input wire logic signed [SMP_W-1:0] rotated_real,
	input wire logic signed [SMP_W-1:0] rotated_imag,
	input wire logic last_out,
	output int fail_count,
	output int pending_count
);
	localparam int HEAD_LEN = 30;
	localparam int STEPS = 15;
	localparam int SUM_HI = 8388607;
	localparam int SUM_LO = -8388608;
	localparam int SMP_HI = 131071;
	localparam int SMP_LO = -131072;
	localparam int HALF_TURN = 32768;
	localparam int QUARTER_TURN = 16384;
	localparam longint GAIN_COMP = 39797;
	localparam int arc_units [STEPS] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41,
		20, 10, 5, 3, 1, 1};

	typedef struct {
		logic signed [SMP_W-1:0] re;
		logic signed [SMP_W-1:0] im;
		logic last;
	} rotated_t;

	rotated_t rotated_q[$];
	logic signed [SMP_W-1:0] held_re [HEAD_LEN];
	logic signed [SMP_W-1:0] held_im [HEAD_LEN];
	int acc_re;
	int acc_im;
	int held_n;
	logic [ANG_W-1:0] phase;
	logic phase_known;

	assign pending_count = rotated_q.size();

	function automatic int clip_sum(int v);
		if (v > SUM_HI)
			return SUM_HI;
		if (v < SUM_LO)
			return SUM_LO;
		return v;
	endfunction

	function automatic longint clip_sample(longint v);
		if (v > SMP_HI)
			return SMP_HI;
		if (v < SMP_LO)
			return SMP_LO;
		return v;
	endfunction

	function automatic logic [ANG_W-1:0] sum_phase(int sr, int si);
		longint x;
		longint y;
		longint xn;
		int z;
		z = 0;
		x = sr;
		y = si;
		if (sr == 0 && si == 0)
			return '0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = HALF_TURN;
		end
		for (int i = 0; i < STEPS; i++) begin
			if (y > 0) begin
				xn = x + (y >>> i);
				y = y - (x >>> i);
				z += arc_units[i];
			end else begin
				xn = x - (y >>> i);
				y = y + (x >>> i);
				z -= arc_units[i];
			end
			x = xn;
		end
		return z[ANG_W-1:0];
	endfunction

	function automatic rotated_t derotate(logic signed [SMP_W-1:0] re,
			logic signed [SMP_W-1:0] im, logic fin, logic [ANG_W-1:0] ang);
		longint x;
		longint y;
		longint xn;
		int z;
		logic signed [ANG_W-1:0] neg;
		rotated_t r;
		neg = -ang;
		z = neg;
		x = longint'(re) * 16;
		y = longint'(im) * 16;
		if (z > QUARTER_TURN) begin
			x = -x;
			y = -y;
			z -= HALF_TURN;
		end else if (z < -QUARTER_TURN) begin
			x = -x;
			y = -y;
			z += HALF_TURN;
		end
		for (int i = 0; i < STEPS; i++) begin
			if (z >= 0) begin
				xn = x - (y >>> i);
				y = y + (x >>> i);
				z -= arc_units[i];
			end else begin
				xn = x + (y >>> i);
				y = y - (x >>> i);
				z += arc_units[i];
			end
			x = xn;
		end
		r.re = SMP_W'(clip_sample((x * GAIN_COMP + (longint'(1) << 19)) >>> 20));
		r.im = SMP_W'(clip_sample((y * GAIN_COMP + (longint'(1) << 19)) >>> 20));
		r.last = fin;
		return r;
	endfunction

	task automatic take_sample(logic signed [SMP_W-1:0] re, logic signed [SMP_W-1:0] im,
			logic fin);
		if (phase_known) begin
			rotated_q.push_back(derotate(re, im, fin, phase));
		end else begin
			if (held_n < HEAD_LEN) begin
				held_re[held_n] = re;
				held_im[held_n] = im;
				held_n++;
				acc_re = clip_sum(acc_re + re);
				acc_im = clip_sum(acc_im + im);
			end
			if (held_n >= HEAD_LEN || fin) begin
				phase = sum_phase(acc_re, acc_im);
				phase_known = 1'b1;
				for (int k = 0; k < held_n; k++)
					rotated_q.push_back(derotate(held_re[k], held_im[k],
						fin && (k + 1 == held_n), phase));
			end
		end
		if (fin) begin
			acc_re = 0;
			acc_im = 0;
			held_n = 0;
			phase_known = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rotated_t exp_r;
		if (!arst_n) begin
			acc_re = 0;
			acc_im = 0;
			held_n = 0;
			phase = '0;
			phase_known = 1'b0;
			fail_count <= 0;
			rotated_q.delete();
		end else begin
			if (sample_valid && sample_ready)
				take_sample(sample_real, sample_imag, last_sample);
			if (result_valid && result_ready) begin
				if (rotated_q.size() == 0) begin
					$error("unexpected result transfer");
					fail_count <= fail_count + 1;
				end else begin
					exp_r = rotated_q.pop_front();
					if (rotated_real !== exp_r.re) begin
						$error("rotated_real expected %0d actual %0d", exp_r.re, rotated_real);
						fail_count <= fail_count + 1;
					end
					if (rotated_imag !== exp_r.im) begin
						$error("rotated_imag expected %0d actual %0d", exp_r.im, rotated_imag);
						fail_count <= fail_count + 1;
					end
					if (last_out !== exp_r.last) begin
						$error("last_out expected %0d actual %0d", exp_r.last, last_out);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

[tb/zero_order_phase_correct_test.sv]
`timescale 1ns / 1ps
module zero_order_phase_correct_test;
	import zopc_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 700;
	localparam int SAMPLE_TARGET = 260;
	localparam int SMP_HI = 131071;
	localparam int SMP_LO = -131072;

	typedef enum int {FILL_RANDOM, FILL_MAX, FILL_MIN, FILL_ZERO, FILL_CORNER, FILL_SMALL}
		fill_t;

	logic clk;
	logic arst_n;
	logic sample_valid;
	logic sample_ready;
	logic signed [SMP_W-1:0] sample_real;
	logic signed [SMP_W-1:0] sample_imag;
	logic last_sample;
	logic result_valid;
	logic result_ready;
	logic signed [SMP_W-1:0] rotated_real;
	logic signed [SMP_W-1:0] rotated_imag;
	logic last_out;
	int fail_count;
	int pending_count;
	int sent;
	int idle_cycles;
	logic no_gaps;

	zero_order_phase_correct uut (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_ready(sample_ready),
		.sample_real(sample_real), .sample_imag(sample_imag), .last_sample(last_sample),
		.result_valid(result_valid), .result_ready(result_ready),
		.rotated_real(rotated_real), .rotated_imag(rotated_imag), .last_out(last_out)
	);

	zopc_phase_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_ready(sample_ready),
		.sample_real(sample_real), .sample_imag(sample_imag), .last_sample(last_sample),
		.result_valid(result_valid), .result_ready(result_ready),
		.rotated_real(rotated_real), .rotated_imag(rotated_imag), .last_out(last_out),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample_real = '0;
		sample_imag = '0;
		last_sample = 1'b0;
		result_ready = 1'b0;
		no_gaps = 1'b0;
		sent = 0;
	end

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk)
		if (arst_n)
			result_ready <= no_gaps ? 1'b1 : ($urandom_range(99) >= 12);

	// stall watchdog
	always @(posedge clk) begin
		if (!arst_n || (sample_valid && sample_ready) || (result_valid && result_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic logic signed [SMP_W-1:0] pick(fill_t mode);
		case (mode)
			FILL_MAX: return SMP_W'(SMP_HI);
			FILL_MIN: return SMP_W'(SMP_LO);
			FILL_ZERO: return '0;
			FILL_SMALL: return SMP_W'($signed(18'($urandom_range(4000))) - 2000);
			FILL_CORNER: begin
				case ($urandom_range(3))
					0: return SMP_W'(SMP_HI);
					1: return SMP_W'(SMP_LO);
					2: return '0;
					default: return 18'($urandom);
				endcase
			end
			default: return 18'($urandom);
		endcase
	endfunction

	task automatic send_sample(logic signed [SMP_W-1:0] re, logic signed [SMP_W-1:0] im,
			logic fin);
		if (!no_gaps && $urandom_range(99) < 12) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_real <= re;
		sample_imag <= im;
		last_sample <= fin;
		do
			@(posedge clk);
		while (!(sample_valid && sample_ready));
		sent++;
		no_gaps <= (sent >= 120 && sent < 175);
	endtask

	task automatic send_record(int len, fill_t mode);
		for (int i = 0; i < len; i++)
			send_sample(pick(mode), pick(mode), i == len - 1);
	endtask

	initial begin
		int len;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_record(1, FILL_ZERO);
		send_record(3, FILL_MAX);
		send_record(2, FILL_MIN);
		send_record(19, FILL_CORNER);
		while (sent < SAMPLE_TARGET) begin
			case ($urandom_range(4))
				0: len = $urandom_range(5, 1);
				1: len = 30;
				2: len = $urandom_range(45, 31);
				default: len = $urandom_range(29, 6);
			endcase
			case ($urandom_range(9))
				0: send_record(len, FILL_CORNER);
				1: send_record(len, FILL_SMALL);
				2: send_record(len, FILL_ZERO);
				default: send_record(len, FILL_RANDOM);
			endcase
		end
		sample_valid <= 1'b0;
		while (pending_count != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
